FILE: src/hdt_pkg.sv
// Package for the double-hashing hash table engine.
// Holds the payload structs, operation and status codes, and the controller/datapath link.
// No dependencies.
package hdt_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int TABLE_LOG2_DEF = 7;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed field widths on the ports.
	localparam int IN_KEY_W    = 32;
	localparam int IN_VALUE_W  = 32;
	localparam int SLOT_W      = 7;
	localparam int OUT_VALUE_W = 32;
	localparam int COUNT_W     = 8;

	// The probe stride ((key & 0xf0) >> 6) | 1 depends only on this key bit.
	localparam int STRIDE_KEY_BIT = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_ERASE  = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_DUP  = 3'd1,
		ST_MISS = 3'd2,
		ST_FULL = 3'd3,
		ST_RSVD = 3'd4
	} status_t;

	typedef struct packed {
		op_t                   op;
		logic [IN_KEY_W-1:0]   key;
		logic [IN_VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		status_t                status;
		logic [SLOT_W-1:0]      slot;
		logic [OUT_VALUE_W-1:0] value_out;
		logic [COUNT_W-1:0]     entry_count;
	} result_t;

	// Which result the datapath captures when an operation ends.
	typedef enum logic [2:0] {
		RES_RSVD,
		RES_MISS,
		RES_FULL,
		RES_DONE,
		RES_DUP,
		RES_FOUND
	} res_sel_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_VREAD,
		S_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     advance;
		logic     ins_write;
		logic     erase;
		logic     val_read;
		logic     res_load;
		res_sel_t res_sel;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic new_rsvd;
		op_t  new_op;
		op_t  op;
		logic hit;
		logic empty;
		logic last;
	} ctl_sts_t;

endpackage

FILE: src/hdt_datapath.sv
// Datapath of the hash table engine: key and value stores, slot valid bits, probe
// address generation, entry counter and result register.
// Depends on hdt_pkg.
module hdt_datapath #(
	parameter int TABLE_LOG2 = hdt_pkg::TABLE_LOG2_DEF,
	parameter int KEY_BITS   = hdt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = hdt_pkg::VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hdt_pkg::cmd_t    cmd,
	input  hdt_pkg::ctl_cmd_t ctl,
	output hdt_pkg::ctl_sts_t sts,
	output hdt_pkg::result_t result
);
	import hdt_pkg::*;

	localparam int TBL_SIZE = 1 << TABLE_LOG2;
	localparam int CNT_W    = TABLE_LOG2 + 1;

	logic [KEY_BITS-1:0]   key_in;
	logic [VALUE_BITS-1:0] value_in;
	logic [TABLE_LOG2-1:0] home_in;
	logic [TABLE_LOG2-1:0] stride_in;

	op_t                   op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [TABLE_LOG2-1:0] step_q;
	logic [TABLE_LOG2-1:0] pos_q;
	logic [TABLE_LOG2-1:0] rd_slot_q;
	logic [TABLE_LOG2-1:0] cnt_q;
	logic [CNT_W-1:0]      count_q;

	logic [KEY_BITS-1:0]   key_mem [TBL_SIZE];
	logic [VALUE_BITS-1:0] val_mem [TBL_SIZE];
	logic [TBL_SIZE-1:0]   valid_q;

	logic [KEY_BITS-1:0]   key_rd_q;
	logic                  valid_rd_q;
	logic [VALUE_BITS-1:0] val_rd_q;

	logic                  rd_en;
	logic [TABLE_LOG2-1:0] rd_addr;
	logic [TABLE_LOG2-1:0] step_sel;
	logic [CNT_W-1:0]      count_nx;
	logic [SLOT_W-1:0]     slot_ext;
	logic [OUT_VALUE_W-1:0] value_ext;
	logic [COUNT_W-1:0]    count_ext;
	result_t               result_q;

	// Fit the incoming key and value to the stored widths, and derive home slot and stride.
	always_comb begin
		for (int i = 0; i < KEY_BITS; i++) begin
			key_in[i] = (i < IN_KEY_W) ? cmd.key[i] : 1'b0;
		end
		for (int i = 0; i < VALUE_BITS; i++) begin
			value_in[i] = (i < IN_VALUE_W) ? cmd.value[i] : 1'b0;
		end
		for (int i = 0; i < TABLE_LOG2; i++) begin
			home_in[i] = (i < KEY_BITS) ? key_in[i] : 1'b0;
		end
		stride_in = '0;
		stride_in[0] = 1'b1;
		stride_in[1] = key_in[STRIDE_KEY_BIT];
	end

	// One key-store read per cycle while probing: the home slot on load, then the next slot.
	assign rd_en    = ctl.load | ctl.advance;
	assign rd_addr  = ctl.load ? home_in : pos_q;
	assign step_sel = ctl.load ? stride_in : step_q;

	// Operation registers, captured on the transfer of a new command.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q    <= cmd.op;
			key_q   <= key_in;
			value_q <= value_in;
			step_q  <= stride_in;
		end
	end

	// Probe address and probe index follow each issued read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			pos_q     <= rd_addr + step_sel;
			rd_slot_q <= rd_addr;
		end
		if (ctl.load) begin
			cnt_q <= '0;
		end else if (ctl.advance) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Key store: written on insert at the probed slot, read with a registered output.
	always_ff @(posedge clk) begin
		if (ctl.ins_write) begin
			key_mem[rd_slot_q] <= key_q;
		end
		if (rd_en) begin
			key_rd_q   <= key_mem[rd_addr];
			valid_rd_q <= valid_q[rd_addr];
		end
	end

	// Value store: written on insert, read after a lookup hit.
	always_ff @(posedge clk) begin
		if (ctl.ins_write) begin
			val_mem[rd_slot_q] <= value_q;
		end
		if (ctl.val_read) begin
			val_rd_q <= val_mem[rd_slot_q];
		end
	end

	// Slot valid bits; a slot that is not valid reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.ins_write) begin
			valid_q[rd_slot_q] <= 1'b1;
		end else if (ctl.erase) begin
			valid_q[rd_slot_q] <= 1'b0;
		end
	end

	// Occupied slot count after the current operation.
	always_comb begin
		count_nx = count_q;
		if (ctl.ins_write) begin
			count_nx = count_q + 1'b1;
		end else if (ctl.erase && count_q != '0) begin
			count_nx = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nx;
		end
	end

	// Status back to the controller.
	always_comb begin
		sts.new_rsvd = &key_in;
		sts.new_op   = cmd.op;
		sts.op       = op_q;
		sts.hit      = valid_rd_q && (key_rd_q == key_q);
		sts.empty    = !valid_rd_q;
		sts.last     = &cnt_q;
	end

	// Fit slot, value and count to the result field widths.
	always_comb begin
		for (int i = 0; i < SLOT_W; i++) begin
			slot_ext[i] = (i < TABLE_LOG2) ? rd_slot_q[i] : 1'b0;
		end
		for (int i = 0; i < OUT_VALUE_W; i++) begin
			value_ext[i] = (i < VALUE_BITS) ? val_rd_q[i] : 1'b0;
		end
		for (int i = 0; i < COUNT_W; i++) begin
			count_ext[i] = (i < CNT_W) ? count_nx[i] : 1'b0;
		end
	end

	// Result register, loaded once when an operation ends.
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			result_q.entry_count <= count_ext;
			result_q.slot        <= '0;
			result_q.value_out   <= '0;
			unique case (ctl.res_sel)
				RES_RSVD: begin
					result_q.status <= ST_RSVD;
				end
				RES_MISS: begin
					result_q.status <= ST_MISS;
				end
				RES_FULL: begin
					result_q.status <= ST_FULL;
				end
				RES_DONE: begin
					result_q.status <= ST_OK;
					result_q.slot   <= slot_ext;
				end
				RES_DUP: begin
					result_q.status <= ST_DUP;
					result_q.slot   <= slot_ext;
				end
				RES_FOUND: begin
					result_q.status    <= ST_OK;
					result_q.slot      <= slot_ext;
					result_q.value_out <= value_ext;
				end
				default: begin
					result_q.status <= ST_MISS;
				end
			endcase
		end
	end

	assign result = result_q;

endmodule

FILE: src/hdt_controller.sv
// Controller state machine of the hash table engine: steps the probe sequence and
// decides how each operation ends.
// Depends on hdt_pkg.
module hdt_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hdt_pkg::ctl_sts_t sts,
	output hdt_pkg::ctl_cmd_t ctl,
	output logic              busy,
	output logic              done
);
	import hdt_pkg::*;

	state_t state_q;
	state_t state_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_nx    = state_q;
		ctl         = '0;
		ctl.res_sel = RES_MISS;
		done        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (sts.new_rsvd) begin
						ctl.res_load = 1'b1;
						ctl.res_sel  = RES_RSVD;
						state_nx     = S_RESULT;
					end else if (sts.new_op == OP_UNUSED) begin
						ctl.res_load = 1'b1;
						ctl.res_sel  = RES_MISS;
						state_nx     = S_RESULT;
					end else begin
						ctl.load = 1'b1;
						state_nx = S_PROBE;
					end
				end
			end
			S_PROBE: begin
				// The key read for the current slot is on hand; stop here or read the next slot.
				unique case (sts.op)
					OP_INSERT: begin
						if (sts.hit) begin
							ctl.res_load = 1'b1;
							ctl.res_sel  = RES_DUP;
							state_nx     = S_RESULT;
						end else if (sts.empty) begin
							ctl.ins_write = 1'b1;
							ctl.res_load  = 1'b1;
							ctl.res_sel   = RES_DONE;
							state_nx      = S_RESULT;
						end else if (sts.last) begin
							ctl.res_load = 1'b1;
							ctl.res_sel  = RES_FULL;
							state_nx     = S_RESULT;
						end else begin
							ctl.advance = 1'b1;
						end
					end
					OP_LOOKUP: begin
						if (sts.hit) begin
							ctl.val_read = 1'b1;
							state_nx     = S_VREAD;
						end else if (sts.last) begin
							ctl.res_load = 1'b1;
							ctl.res_sel  = RES_MISS;
							state_nx     = S_RESULT;
						end else begin
							ctl.advance = 1'b1;
						end
					end
					OP_ERASE: begin
						if (sts.hit) begin
							ctl.erase    = 1'b1;
							ctl.res_load = 1'b1;
							ctl.res_sel  = RES_DONE;
							state_nx     = S_RESULT;
						end else if (sts.last) begin
							ctl.res_load = 1'b1;
							ctl.res_sel  = RES_MISS;
							state_nx     = S_RESULT;
						end else begin
							ctl.advance = 1'b1;
						end
					end
					default: begin
						ctl.res_load = 1'b1;
						ctl.res_sel  = RES_MISS;
						state_nx     = S_RESULT;
					end
				endcase
			end
			S_VREAD: begin
				ctl.res_load = 1'b1;
				ctl.res_sel  = RES_FOUND;
				state_nx     = S_RESULT;
			end
			S_RESULT: begin
				done     = 1'b1;
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: src/double_hash_table_engine_unit.sv
// Open-addressing hash table with double hashing; insert, lookup and erase.
// Each operation probes slots from the home slot with the key's stride, one key-store read
// per cycle, then loads the result register; a successful lookup adds a value-store read
// first. A reserved key or an unused op code loads the result on the command transfer itself.
// busy stays high through the strobe cycle, so a new command is taken only after the last result.
// The result is shown for exactly one cycle with done; the receiver cannot stall.
// Reset empties the table at once by clearing the per-slot valid bits and the entry count.
module double_hash_table_engine_unit #(
	parameter int TABLE_LOG2 = hdt_pkg::TABLE_LOG2_DEF,
	parameter int KEY_BITS   = hdt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = hdt_pkg::VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  hdt_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done,
	output hdt_pkg::result_t result
);
	import hdt_pkg::*;

	ctl_cmd_t ctl;
	ctl_sts_t sts;

	// Sequencing of each operation.
	hdt_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// Stores, probe addressing and result register.
	hdt_datapath #(
		.TABLE_LOG2 (TABLE_LOG2),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.result (result)
	);

endmodule

FILE: dv/hash_table_shadow_pkg.sv
`timescale 1ns / 100ps
// Shadow copy of the double-hashing hash table and the queue of results it predicts.
// Depends on hdt_pkg for the command and result structs and the op and status codes.
package hash_table_shadow_pkg;
	import hdt_pkg::*;

	localparam int TABLE_SIZE = 1 << TABLE_LOG2_DEF;
	localparam logic [IN_KEY_W-1:0] EMPTY_KEY = '1;

	class hash_table_shadow;
		logic [IN_KEY_W-1:0]    keys [TABLE_SIZE];
		logic [IN_VALUE_W-1:0]  values [TABLE_SIZE];
		int unsigned            entries;
		result_t                expected_q[$];
		int unsigned            fails;
		int unsigned            results_seen;
		int unsigned            status_seen [5];

		function new();
			for (int i = 0; i < TABLE_SIZE; i++) begin
				keys[i] = EMPTY_KEY;
				values[i] = '0;
			end
			entries = 0;
			fails = 0;
			results_seen = 0;
			for (int i = 0; i < 5; i++)
				status_seen[i] = 0;
		endfunction

		// The stride depends only on key bit 7, so it is always 1 or 3.
		function logic [SLOT_W-1:0] probe_stride(logic [IN_KEY_W-1:0] key);
			return {{(SLOT_W-2){1'b0}}, key[STRIDE_KEY_BIT], 1'b1};
		endfunction

		// Slot of the first copy of the key on its probe path, or -1 when absent.
		function int first_copy(logic [IN_KEY_W-1:0] key);
			logic [SLOT_W-1:0] pos;
			pos = key[SLOT_W-1:0];
			for (int i = 0; i < TABLE_SIZE; i++) begin
				if (keys[pos] == key)
					return int'(pos);
				pos = pos + probe_stride(key);
			end
			return -1;
		endfunction

		// Applies an accepted command to the shadow table and queues its result.
		function void note_command(cmd_t c);
			result_t           res;
			logic [SLOT_W-1:0] pos;
			int                hit;
			res = '0;
			res.status = ST_MISS;
			if (c.key == EMPTY_KEY) begin
				res.status = ST_RSVD;
			end else begin
				case (c.op)
					OP_INSERT: begin
						res.status = ST_FULL;
						pos = c.key[SLOT_W-1:0];
						for (int i = 0; i < TABLE_SIZE; i++) begin
							if (keys[pos] == EMPTY_KEY) begin
								keys[pos] = c.key;
								values[pos] = c.value;
								entries++;
								res.status = ST_OK;
								res.slot = pos;
								break;
							end
							if (keys[pos] == c.key) begin
								res.status = ST_DUP;
								res.slot = pos;
								break;
							end
							pos = pos + probe_stride(c.key);
						end
					end
					OP_LOOKUP: begin
						hit = first_copy(c.key);
						if (hit >= 0) begin
							res.status = ST_OK;
							res.slot = SLOT_W'(hit);
							res.value_out = values[hit];
						end
					end
					OP_ERASE: begin
						hit = first_copy(c.key);
						if (hit >= 0) begin
							keys[hit] = EMPTY_KEY;
							if (entries > 0)
								entries--;
							res.status = ST_OK;
							res.slot = SLOT_W'(hit);
						end
					end
					default: ;
				endcase
			end
			res.entry_count = COUNT_W'(entries);
			expected_q.push_back(res);
		endfunction

		// Compares one result transfer with the oldest prediction.
		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (got.status < 5)
				status_seen[got.status]++;
			if (expected_q.size() == 0) begin
				$error("result transfer with no command outstanding (status %0d, slot %0d)",
					got.status, got.slot);
				fails++;
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				fails++;
			end
			if (got.slot !== want.slot) begin
				$error("slot: expected %0d, actual %0d", want.slot, got.slot);
				fails++;
			end
			if (got.value_out !== want.value_out) begin
				$error("value_out: expected 0x%08h, actual 0x%08h", want.value_out, got.value_out);
				fails++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, actual %0d", want.entry_count,
					got.entry_count);
				fails++;
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for double_hash_table_engine_unit: directed, fill-to-full and random command streams.
// Depends on hdt_pkg and hash_table_shadow_pkg; results are checked against the shadow table.
module tb_top;
	import hdt_pkg::*;
	import hash_table_shadow_pkg::*;

	localparam int POOL_SIZE   = 120;
	localparam int FILL_KEYS   = 136;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 140;

	logic    clk;
	logic    arst_n;
	logic    start;
	cmd_t    cmd;
	logic    busy;
	logic    done;
	result_t result;

	hash_table_shadow   shadow;
	logic [IN_KEY_W-1:0] key_pool [POOL_SIZE];
	logic [IN_KEY_W-1:0] fill_keys [FILL_KEYS];
	int unsigned         commands_sent;
	int unsigned         stall_cycles = 0;
	bit                  no_idle;

	double_hash_table_engine_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Every strobed result is a transfer; check it against the shadow table.
	always @(posedge clk) begin
		if (arst_n && done)
			shadow.check_result(result);
	end

	// Count cycles in which neither a command nor a result transfer happens.
	always @(posedge clk) begin
		if ((arst_n && start && !busy) || (arst_n && done))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("Timeout after %0d cycles without a transfer", STALL_LIMIT);
		$display("status: fail");
		$finish;
	end

	function automatic cmd_t make_cmd(op_t op, logic [IN_KEY_W-1:0] key,
		logic [IN_VALUE_W-1:0] value);
		cmd_t c;
		c.op = op;
		c.key = key;
		c.value = value;
		return c;
	endfunction

	// Mostly keys from the pool so that hits, duplicates and probe chains happen.
	function automatic cmd_t random_command(int pool_n);
		int unsigned         pick;
		logic [IN_KEY_W-1:0] key;
		op_t                 op;
		key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_n - 1)]
			: IN_KEY_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = OP_INSERT;
		else if (pick < 70)
			op = OP_LOOKUP;
		else if (pick < 95)
			op = OP_ERASE;
		else if (pick < 98)
			op = OP_UNUSED;
		else begin
			op = op_t'($urandom_range(0, 3));
			key = EMPTY_KEY;
		end
		return make_cmd(op, key, IN_VALUE_W'($urandom));
	endfunction

	// Drives one command after a random idle gap and waits for its transfer.
	task automatic send_command(input cmd_t c);
		int gap;
		if ($urandom_range(0, 39) == 0)
			no_idle = !no_idle;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		shadow.note_command(c);
		commands_sent++;
	endtask

	// Drop start so the last command is not taken again, then wait for all results.
	task automatic wait_drained();
		start <= 1'b0;
		while (shadow.outstanding() != 0)
			@(posedge clk);
	endtask

	// Edge cases: empty table, reserved key, unused op, duplicates, wrap and reinsertion
	// after an erase that leaves a hole on the probe path.
	task automatic run_directed();
		send_command(make_cmd(OP_LOOKUP, 32'h0000_0005, 32'h0));
		send_command(make_cmd(OP_ERASE, 32'h0000_0005, 32'h0));
		send_command(make_cmd(OP_INSERT, EMPTY_KEY, 32'hFFFF_FFFF));
		send_command(make_cmd(OP_LOOKUP, EMPTY_KEY, 32'h0));
		send_command(make_cmd(OP_ERASE, EMPTY_KEY, 32'h0));
		send_command(make_cmd(OP_UNUSED, EMPTY_KEY, 32'h0));
		send_command(make_cmd(OP_UNUSED, 32'h0000_0012, 32'hA5A5_A5A5));
		send_command(make_cmd(OP_INSERT, 32'h0000_0000, 32'h0000_0000));
		send_command(make_cmd(OP_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFF));
		send_command(make_cmd(OP_LOOKUP, 32'h0000_0000, 32'h0));
		send_command(make_cmd(OP_LOOKUP, 32'hFFFF_FFFE, 32'h0));
		send_command(make_cmd(OP_INSERT, 32'h0000_0000, 32'h0000_1234));
		send_command(make_cmd(OP_LOOKUP, 32'h0000_0000, 32'h0));
		// Same home slot as the FFFF_FFFE entry, so the probe wraps past the top.
		send_command(make_cmd(OP_INSERT, 32'h0000_00FE, 32'h0000_00FE));
		send_command(make_cmd(OP_INSERT, 32'h0000_0080, 32'h0000_0080));
		send_command(make_cmd(OP_INSERT, 32'h0000_0180, 32'h0000_0180));
		send_command(make_cmd(OP_INSERT, 32'h0000_0280, 32'h0000_0280));
		send_command(make_cmd(OP_ERASE, 32'h0000_0080, 32'h0));
		// The freed slot lets a second copy of the same key in.
		send_command(make_cmd(OP_INSERT, 32'h0000_0280, 32'h5555_AAAA));
		send_command(make_cmd(OP_LOOKUP, 32'h0000_0280, 32'h0));
		send_command(make_cmd(OP_ERASE, 32'h0000_0280, 32'h0));
		send_command(make_cmd(OP_LOOKUP, 32'h0000_0280, 32'h0));
		send_command(make_cmd(OP_ERASE, 32'h0000_0280, 32'h0));
		send_command(make_cmd(OP_ERASE, 32'h0000_0180, 32'h0));
		send_command(make_cmd(OP_ERASE, 32'h0000_0000, 32'h0));
		send_command(make_cmd(OP_ERASE, 32'hFFFF_FFFE, 32'h0));
	endtask

	task automatic run_random(int count, int pool_n);
		for (int i = 0; i < count; i++)
			send_command(random_command(pool_n));
	endtask

	// Fill the table past capacity, probe it while full, then empty it again.
	task automatic run_fill();
		for (int i = 0; i < FILL_KEYS; i++)
			send_command(make_cmd(OP_INSERT, fill_keys[i], IN_VALUE_W'($urandom)));
		for (int i = 0; i < 12; i++)
			send_command(make_cmd(OP_LOOKUP, fill_keys[$urandom_range(0, FILL_KEYS - 1)],
				32'h0));
		for (int i = 0; i < 4; i++)
			send_command(make_cmd(OP_INSERT, fill_keys[$urandom_range(0, FILL_KEYS - 1)],
				IN_VALUE_W'($urandom)));
		for (int i = 0; i < 8; i++)
			send_command(make_cmd(op_t'($urandom_range(1, 2)), IN_KEY_W'($urandom), 32'h0));
		for (int i = 0; i < FILL_KEYS; i++)
			send_command(make_cmd(OP_ERASE, fill_keys[i], 32'h0));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		no_idle = 1'b0;
		commands_sent = 0;
		shadow = new();

		// Half the pool shares four home slots to build long probe chains.
		for (int i = 0; i < POOL_SIZE; i++) begin
			key_pool[i] = IN_KEY_W'($urandom);
			if (i % 2 == 0)
				key_pool[i][SLOT_W-1:0] = SLOT_W'($urandom_range(0, 3) * 42);
			if (key_pool[i] == EMPTY_KEY)
				key_pool[i][0] = 1'b0;
		end
		for (int i = 0; i < FILL_KEYS; i++) begin
			fill_keys[i] = IN_KEY_W'($urandom);
			if (fill_keys[i] == EMPTY_KEY)
				fill_keys[i][0] = 1'b0;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(350, 40);
		// Hold the sender until every outstanding result has come back.
		wait_drained();
		run_fill();
		run_random(300, POOL_SIZE);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d commands and checked %0d results", commands_sent,
			shadow.results_seen);
		$display("Statuses seen: ok %0d, duplicate %0d, miss %0d, full %0d, reserved %0d",
			shadow.status_seen[0], shadow.status_seen[1], shadow.status_seen[2],
			shadow.status_seen[3], shadow.status_seen[4]);
		if (shadow.fails == 0 && shadow.outstanding() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
